// ===== rtl/core/lse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line sensor PID error terms: shared package
// Types and fixed constants used by the sequencer, divider and update logic.
// ----------------------------------------------------------------------------
package lse_pkg;

  // Field widths fixed by the item format.
  localparam int MASK_W     = 8;
  localparam int ERR_W      = 6;
  localparam int INTEG_W    = 8;
  localparam int DERIV_W    = 7;
  localparam int WEIGHT_W   = 4;
  localparam int LIMIT_W    = 7;
  localparam int POS_SUM_W  = 5;
  localparam int COUNT_W    = 4;
  localparam int DIVIDEND_W = WEIGHT_W + POS_SUM_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_WEIGHT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 1'd1;

  // Register reset values.
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd2;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd127;

  // Input item commands.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Control from the sequencer to the state update logic.
  typedef struct packed {
    logic load;
    logic clear;
  } lse_upd_ctl_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } lse_div_stat_t;

  // One result item.
  typedef struct packed {
    logic signed [DERIV_W-1:0] error_derivative;
    logic signed [INTEG_W-1:0] error_integral;
    logic signed [ERR_W-1:0]   error_value;
  } lse_terms_t;

endpackage
`default_nettype wire

// ===== rtl/core/lse_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line sensor PID error terms: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lse_div
  import lse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [COUNT_W-1:0]    divisor,
  output lse_div_stat_t              stat,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]    rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [COUNT_W-1:0]    dsr_r, dsr_nxt;
  logic [COUNT_W:0]      shifted;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_r, quo_r[DIVIDEND_W-1]};
    fits    = (shifted >= {1'b0, dsr_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? COUNT_W'(shifted - {1'b0, dsr_r}) : shifted[COUNT_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  // The quotient is complete in the cycle after the last step.
  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == LAST_STEP);
  assign quotient  = quo_nxt;

  // A division ends by leaving the busy state.
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done && !start |=> !busy_r)
    else $error("divider still busy after its last step");

  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dsr_r))
    else $error("partial remainder not below divisor");

  // Division by zero is never started.
  a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (divisor != '0))
    else $error("divider started with a zero divisor");

endmodule
`default_nettype wire

// ===== rtl/core/lse_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line sensor PID error terms: state update
// Holds previous error, clamped integral and filtered derivative.
// ----------------------------------------------------------------------------
module lse_update
  import lse_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lse_upd_ctl_t              ctl,
  input  wire logic signed [ERR_W-1:0]   err,
  input  wire logic        [LIMIT_W-1:0] limit,
  output logic signed      [ERR_W-1:0]   prev_error,
  output lse_terms_t                     terms
);

  logic signed [ERR_W-1:0]   prev_r, prev_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [DERIV_W-1:0] deriv_r, deriv_nxt;

  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W:0]   lim_pos;
  logic signed [INTEG_W:0]   lim_neg;
  logic signed [ERR_W:0]     delta;
  logic signed [10:0]        deriv_ext;
  logic signed [10:0]        deriv_acc;
  logic signed [10:0]        deriv_shr;
  logic signed [INTEG_W-1:0] integ_upd;
  logic signed [DERIV_W-1:0] deriv_upd;

  // Integral: reset on zero error, otherwise accumulate and saturate.
  always_comb begin
    integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err);
    lim_pos   = $signed({2'b00, limit});
    lim_neg   = -lim_pos;
    if (err == '0) begin
      integ_upd = '0;
    end else if (integ_sum > lim_pos) begin
      integ_upd = INTEG_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_upd = INTEG_W'(lim_neg);
    end else begin
      integ_upd = INTEG_W'(integ_sum);
    end
  end

  // Derivative filter: (7*d + delta) shifted right by three with floor.
  always_comb begin
    delta     = (ERR_W+1)'(err) - (ERR_W+1)'(prev_r);
    deriv_ext = 11'(deriv_r);
    deriv_acc = (deriv_ext <<< 3) - deriv_ext + 11'(delta);
    deriv_shr = deriv_acc >>> 3;
    if (deriv_shr > 11'sd63) begin
      deriv_upd = 7'sd63;
    end else if (deriv_shr < -11'sd64) begin
      deriv_upd = -7'sd64;
    end else begin
      deriv_upd = DERIV_W'(deriv_shr);
    end
  end

  // A clear command zeroes everything.
  always_comb begin
    if (ctl.clear) begin
      prev_nxt  = '0;
      integ_nxt = '0;
      deriv_nxt = '0;
    end else begin
      prev_nxt  = err;
      integ_nxt = integ_upd;
      deriv_nxt = deriv_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
      deriv_r <= '0;
    end else if (ctl.load) begin
      prev_r  <= prev_nxt;
      integ_r <= integ_nxt;
      deriv_r <= deriv_nxt;
    end
  end

  assign prev_error             = prev_r;
  assign terms.error_value      = prev_nxt;
  assign terms.error_integral   = integ_nxt;
  assign terms.error_derivative = deriv_nxt;

  // After a clear all state is zero.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load && ctl.clear |=> (prev_r == '0) && (integ_r == '0) && (deriv_r == '0))
    else $error("state not zero after clear");

  // An update never leaves the integral outside the limit.
  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load && !ctl.clear && $stable(limit) |=>
      (integ_r <= $signed({1'b0, limit})) && (integ_r >= -$signed({1'b0, limit})))
    else $error("integral outside its limit");

  // A zero error empties the integral.
  a_integ_reset: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load && (err == '0) |=> (integ_r == '0))
    else $error("integral kept on zero error");

endmodule
`default_nettype wire

// ===== rtl/core/line_sensor_pid_error_terms.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line sensor PID error terms
// Centroid error of a line sensor mask with integral and filtered derivative.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the in_ stream: tdata carries the sensor mask and
//   the center flag, tuser carries the command (update or clear). Each item
//   gives exactly one result on the out_ stream with the error, the clamped
//   integral and the filtered derivative.
//   The block works on one item at a time. An update with sensors set goes
//   through these steps after the input transfer: scale and start the
//   divider, run the serial divider (one quotient bit per cycle, the number
//   of steps set by the dividend width), form the error, then update the
//   state and load the result. An empty mask skips the divider; a clear
//   goes straight to the last step.
//   in_tready is high only while the sequencer is idle; the result register
//   frees the sequencer as soon as the result is loaded, so the next item
//   can be taken while the result waits. A new item is taken only once the
//   sequencer is through with the last one. If the receiver stalls with a
//   full result register, the finished item holds in the last step.
//   Registers are written on the cfg_ port (always ready). The user must
//   write them only while idle; the block itself does not enforce this.
//   Reset clears all error state and loads weight 2 and limit 127.
// ----------------------------------------------------------------------------
module line_sensor_pid_error_terms
  import lse_pkg::*;
#(
  parameter int SENSOR_COUNT = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [7:0] sensor_mask, [8] center_flag
  input  wire logic [0:0]            in_tuser,   // [0] command
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,  // [5:0] error_value,
                                                 // [13:6] error_integral,
                                                 // [20:14] error_derivative
  // Configuration writes.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [MASK_W-1:0] SENSOR_BITS = MASK_W'((1 << SENSOR_COUNT) - 1);
  localparam logic [2:0]        SPAN        = 3'(SENSOR_COUNT - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ERR  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [WEIGHT_W-1:0]    weight_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic                   cmd_r;
  logic                   center_r;
  logic                   empty_r;
  logic [POS_SUM_W-1:0]   pos_sum_r, pos_sum_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic                   out_valid_r;
  lse_terms_t             out_terms_r;

  logic [MASK_W-1:0]      mask_in;
  logic                   in_xfer;
  logic                   out_free;
  logic                   div_start;
  logic [DIVIDEND_W-1:0]  quotient;
  lse_div_stat_t          div_stat;
  lse_upd_ctl_t           upd_ctl;
  logic signed [ERR_W-1:0] prev_error;
  lse_terms_t             terms;
  logic [6:0]             offset;
  logic signed [10:0]     err_diff;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ERROR_WEIGHT:   weight_r <= cfg_data[WEIGHT_W-1:0];
        REG_INTEGRAL_LIMIT: limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position sum and count of the set sensors, taken at the input transfer.
  always_comb begin
    mask_in     = in_tdata[MASK_W-1:0] & SENSOR_BITS;
    pos_sum_nxt = '0;
    count_nxt   = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (mask_in[i]) begin
        pos_sum_nxt = pos_sum_nxt + POS_SUM_W'(i);
        count_nxt   = count_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r     <= in_tuser[0];
      center_r  <= in_tdata[MASK_W];
      empty_r   <= (mask_in == '0);
      pos_sum_r <= pos_sum_nxt;
      count_r   <= count_nxt;
    end
  end

  // Scaled position sum goes straight into the divider.
  assign div_start = (state_r == ST_MUL);

  lse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIVIDEND_W'(weight_r * pos_sum_r)),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Centered, saturated error; empty mask: zero if centered, else previous error.
  always_comb begin
    offset   = 7'((weight_r * SPAN) >> 1);
    err_diff = $signed({2'b00, quotient}) - $signed({4'b0000, offset});
    if (empty_r) begin
      err_nxt = center_r ? '0 : prev_error;
    end else if (err_diff > 11'sd31) begin
      err_nxt = 6'sd31;
    end else if (err_diff < -11'sd32) begin
      err_nxt = -6'sd32;
    end else begin
      err_nxt = ERR_W'(err_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ERR) begin
      err_r <= err_nxt;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser[0] == CMD_CLEAR) begin
            state_nxt = ST_FIN;
          end else if (mask_in == '0) begin
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // State update happens when the result register can take the result.
  assign upd_ctl.load  = (state_r == ST_FIN) && out_free;
  assign upd_ctl.clear = (cmd_r == CMD_CLEAR);

  lse_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (upd_ctl),
    .err        (err_r),
    .limit      (limit_r),
    .prev_error (prev_error),
    .terms      (terms)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_ctl.load) begin
      out_terms_r <= terms;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_terms_r.error_derivative,
                       out_terms_r.error_integral, out_terms_r.error_value};

  // An accepted item keeps the input closed in the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after a transfer");

  // Loading a result always shows it on the output.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    upd_ctl.load |=> out_tvalid)
    else $error("result loaded but not valid");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    upd_ctl.load |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while stalled");

  // The divider runs while the sequencer waits on it.
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> div_stat.busy)
    else $error("sequencer waits on an idle divider");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID error terms: regression bench
// Sends sensor items to the block over its input stream, computes the
// expected error, integral and derivative of each item with a bench model,
// or takes them as typed in the directed table, and checks each result
// transfer against them, field by field. A short table of directed items is
// followed by random phases with changing registers and amounts of idling.
// ----------------------------------------------------------------------------
module tb
  import lse_pkg::*;
();

  localparam int SENSOR_COUNT  = 8;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;

  // One input item as the bench sees it.
  typedef struct packed {
    logic       cmd;
    logic [7:0] mask;
    logic       center;
  } sensor_item_t;

  // One row of the directed table: the item and, where it is obvious, the
  // result typed in by hand.
  typedef struct packed {
    sensor_item_t item;
    logic         typed;
    lse_terms_t   want;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata  = '0;   // [7:0] sensor_mask, [8] center_flag
  logic [0:0]            in_tuser  = '0;   // [0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;        // [5:0] error_value, [13:6] error_integral,
                                           // [20:14] error_derivative
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  line_sensor_pid_error_terms #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the registers and of the error state.
  int pred_weight     = int'(WEIGHT_RESET);
  int pred_limit      = int'(LIMIT_RESET);
  int pred_prev_error = 0;
  int pred_integral   = 0;
  int pred_derivative = 0;

  lse_terms_t error_terms_q[$];
  int         fail_count    = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_requests = 0;
  int         line_pos      = 3;

  function automatic lse_terms_t make_terms(input int err, input int integ, input int deriv);
    lse_terms_t t;
    t.error_value      = err[ERR_W-1:0];
    t.error_integral   = integ[INTEG_W-1:0];
    t.error_derivative = deriv[DERIV_W-1:0];
    return t;
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Next error, integral and derivative for one item; advances the state.
  function automatic lse_terms_t predict_terms(input sensor_item_t it);
    int err;
    int pos_sum;
    int count;
    int deriv_acc;
    if (it.cmd == CMD_CLEAR) begin
      pred_prev_error = 0;
      pred_integral   = 0;
      pred_derivative = 0;
      return make_terms(0, 0, 0);
    end
    if (it.mask == '0) begin
      err = it.center ? 0 : pred_prev_error;
    end else begin
      pos_sum = 0;
      count   = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (it.mask[i]) begin
          pos_sum += i;
          count++;
        end
      end
      err = (pred_weight * pos_sum) / count - (pred_weight * (SENSOR_COUNT - 1)) / 2;
      err = clamp(err, -32, 31);
    end
    // The integral restarts whenever the line is centered.
    if (err == 0) begin
      pred_integral = 0;
    end else begin
      pred_integral = clamp(pred_integral + err, -pred_limit, pred_limit);
    end
    deriv_acc       = pred_derivative * 7 + (err - pred_prev_error);
    pred_derivative = clamp(deriv_acc >>> 3, -64, 63);
    pred_prev_error = err;
    return make_terms(err, pred_integral, pred_derivative);
  endfunction

  // Random item: mostly a short run of sensors around a drifting line,
  // with scattered masks, lost lines and clears mixed in.
  function automatic sensor_item_t random_item();
    sensor_item_t it;
    int           r;
    int           run;
    r         = $urandom_range(99);
    it.cmd    = CMD_UPDATE;
    it.center = 1'($urandom_range(1));
    it.mask   = 8'($urandom_range(255));
    if (r < 4) begin
      it.cmd = CMD_CLEAR;
    end else if (r < 14) begin
      it.mask = '0;
    end else if (r >= 30) begin
      line_pos = clamp(line_pos + $urandom_range(2) - 1, 0, SENSOR_COUNT - 1);
      run      = $urandom_range(1, 3);
      it.mask  = 8'(((1 << run) - 1) << line_pos);
    end
    return it;
  endfunction

  // Directed items at the reset settings (weight 2, limit 127).
  directed_row_t directed_rows [21] = '{
    '{'{CMD_UPDATE, 8'h00, 1'b0}, 1'b1, make_terms(0, 0, 0)},     // empty mask, state zero
    '{'{CMD_UPDATE, 8'h01, 1'b0}, 1'b1, make_terms(-7, -7, -1)},  // far low sensor
    '{'{CMD_UPDATE, 8'h80, 1'b0}, 1'b0, '0},                      // far high sensor
    '{'{CMD_CLEAR,  8'hFF, 1'b1}, 1'b1, make_terms(0, 0, 0)},     // clear ignores the fields
    '{'{CMD_UPDATE, 8'hFF, 1'b0}, 1'b0, '0},                      // all sensors
    '{'{CMD_UPDATE, 8'h01, 1'b1}, 1'b1, make_terms(-7, -7, -1)},
    '{'{CMD_UPDATE, 8'h00, 1'b0}, 1'b0, '0},                      // lost line holds error
    '{'{CMD_UPDATE, 8'h00, 1'b1}, 1'b0, '0},                      // lost line, centered
    '{'{CMD_UPDATE, 8'h18, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'h03, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'h55, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'hAA, 1'b1}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'hC0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'h80, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'hF0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'h0F, 1'b0}, 1'b0, '0},
    '{'{CMD_CLEAR,  8'h00, 1'b0}, 1'b1, make_terms(0, 0, 0)},
    '{'{CMD_UPDATE, 8'h80, 1'b0}, 1'b1, make_terms(7, 7, 0)},
    '{'{CMD_UPDATE, 8'h00, 1'b1}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'h7E, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'h81, 1'b0}, 1'b0, '0}
  };

  // Register settings of the random phases; the seventh is drawn at random.
  int phase_weight [PHASE_COUNT] = '{8, 1, 15, 0, 4, 8, 2, 3};
  int phase_limit  [PHASE_COUNT] = '{127, 0, 9, 127, 1, 20, 64, 127};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("line_sensor_pid_error_terms regression: fail");
    $finish;
  end

  // Offer one item until it is taken, then record what it must produce.
  task automatic offer_item(input sensor_item_t it, input logic typed,
                            input lse_terms_t want);
    lse_terms_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, it.center, it.mask};
    in_tuser  <= it.cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_terms(it);
    error_terms_q.push_back(typed ? want : predicted);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (error_terms_q.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == REG_ERROR_WEIGHT) pred_weight = int'(value[WEIGHT_W-1:0]);
    else if (index == REG_INTEGRAL_LIMIT) pred_limit = int'(value[LIMIT_W-1:0]);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  int hold_served = 0;
  int hold_left   = 0;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin
    lse_terms_t got;
    lse_terms_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(lse_terms_t)-1:0];
      if (error_terms_q.size() == 0) begin
        $error("result transfer with no expected terms waiting");
        fail_count++;
      end else begin
        want = error_terms_q.pop_front();
        if (got.error_value !== want.error_value) begin
          $error("error_value: expected %0d, got %0d", want.error_value, got.error_value);
          fail_count++;
        end
        if (got.error_integral !== want.error_integral) begin
          $error("error_integral: expected %0d, got %0d",
                 want.error_integral, got.error_integral);
          fail_count++;
        end
        if (got.error_derivative !== want.error_derivative) begin
          $error("error_derivative: expected %0d, got %0d",
                 want.error_derivative, got.error_derivative);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    int weight;
    int limit;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 10;
    recv_idle_pct = 80;
    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      weight = phase_weight[p];
      limit  = phase_limit[p];
      if (p == 6) begin
        weight = $urandom_range(1, 8);
        limit  = $urandom_range(127);
      end
      // Upper data bits beyond the weight field are don't-care.
      write_register(REG_ERROR_WEIGHT, {3'($urandom_range(7)), 4'(weight)});
      write_register(REG_INTEGRAL_LIMIT, 7'(limit));
      cfg_valid <= 1'b0;

      // Idling: receiver-heavy, then sender-heavy, then none.
      if (p < 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 80;
      end else if (p < 6) begin
        send_idle_pct = 80;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 6 && n == PHASE_ITEMS / 2) drain_results();
        if (p == 7 && n == 40) hold_requests++;
        offer_item(random_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_terms_q.size() != 0) begin
      $error("%0d expected results never arrived", error_terms_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("line_sensor_pid_error_terms regression: pass");
    end else begin
      $display("line_sensor_pid_error_terms regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lse_pkg.sv
rtl/core/lse_div.sv
rtl/core/lse_update.sv
rtl/core/line_sensor_pid_error_terms.sv
bench/tb.sv
